FILE: hdl/afr_pkg.sv
// ----------------------------------------------------------------------------
// Axis-face refraction unit package
// Shared types, constants and helpers for the refraction pipeline.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam int DIR_W    = 16;
	localparam int IOR_W    = 16;
	localparam int SQ_IN_W  = 62;
	localparam int SQ_RT_W  = SQ_IN_W / 2;
	localparam int QUO_W    = 16;
	localparam int DIV_LANES = 4;
	localparam int DEN_W    = SQ_RT_W;
	localparam int ETA_LANE = 3;
	// Front stages, two square roots, the normaliser stages, the divider and the output.
	localparam int LATENCY  = 10 + 2 * SQ_RT_W + QUO_W;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic signed [DIR_W-1:0] DIR_MAX = 16'sh7FFF;
	localparam logic signed [DIR_W-1:0] DIR_MIN = 16'sh8000;
	localparam logic [14:0] COS_ONE = 15'd16384;
	localparam logic [28:0] COS_ONE_SQ = 29'h1000_0000;
	localparam logic [IOR_W-1:0] ETA_ONE = 16'h1000;
	localparam logic [IOR_W-1:0] ETA_SAT = 16'hFFFF;

	typedef logic signed [DIR_W-1:0] dir_t;

	typedef struct packed {
		dir_t             dir_x;
		dir_t             dir_y;
		dir_t             dir_z;
		logic [1:0]       face_axis;
		logic             face_positive;
		logic [IOR_W-1:0] ior_from;
		logic [IOR_W-1:0] ior_to;
	} afr_req_t;

	typedef struct packed {
		dir_t             out_x;
		dir_t             out_y;
		dir_t             out_z;
		logic             reflected;
		logic [IOR_W-1:0] eta_out;
	} afr_rsp_t;

	// Fields that ride alongside a request from the front to the output.
	typedef struct packed {
		dir_t [2:0]       d;
		logic [1:0]       axis;
		logic             tir;
		logic [28:0]      e_num;
		logic [IOR_W-1:0] e_den;
		logic             e_sat;
	} afr_carry_t;

	typedef struct packed {
		afr_carry_t       cy;
		logic             sn_neg;
		logic [2:0][31:0] n1d;
		logic [29:0]      n1c;
	} afr_side1_t;

	typedef struct packed {
		afr_carry_t       cy;
		logic [2:0]       rneg;
		logic [2:0][29:0] rmag;
	} afr_side2_t;

	typedef struct packed {
		afr_carry_t       cy;
		logic [2:0]       rneg;
	} afr_side3_t;

	// Mirror one component; the most negative value saturates.
	function automatic dir_t neg_sat(input dir_t v);
		dir_t r;
		if (v == DIR_MIN) begin
			r = DIR_MAX;
		end else begin
			r = -v;
		end
		return r;
	endfunction

endpackage

FILE: hdl/afr_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage, with a travelling tag.
// ----------------------------------------------------------------------------
module afr_isqrt import afr_pkg::*; #(
	parameter int IN_W  = SQ_IN_W,
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [IN_W-1:0]      in_x,
	input  logic [TAG_W-1:0]     in_tag,
	output logic                 out_valid,
	output logic [IN_W/2-1:0]    out_root,
	output logic [TAG_W-1:0]     out_tag
);

	localparam int RT_W  = IN_W / 2;
	localparam int REM_W = RT_W + 1;

	logic               vld_s  [RT_W+1];
	logic [IN_W-1:0]    x_s    [RT_W+1];
	logic [RT_W-1:0]    root_s [RT_W+1];
	logic [REM_W-1:0]   rem_s  [RT_W+1];
	logic [TAG_W-1:0]   tag_s  [RT_W+1];

	assign vld_s[0]  = in_valid;
	assign x_s[0]    = in_x;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign tag_s[0]  = in_tag;

	for (genvar i = 0; i < RT_W; i++) begin : g_stage
		logic [REM_W+1:0] cat;
		logic [REM_W+1:0] trial;
		logic             ge;

		assign cat   = {rem_s[i], x_s[i][IN_W-1 -: 2]};
		assign trial = {1'b0, root_s[i], 2'b01};
		assign ge    = (cat >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			x_s[i+1]    <= {x_s[i][IN_W-3:0], 2'b00};
			root_s[i+1] <= {root_s[i][RT_W-2:0], ge};
			rem_s[i+1]  <= ge ? REM_W'(cat - trial) : cat[REM_W-1:0];
			tag_s[i+1]  <= tag_s[i];
		end
	end

	assign out_valid = vld_s[RT_W];
	assign out_root  = root_s[RT_W];
	assign out_tag   = tag_s[RT_W];

endmodule

FILE: hdl/afr_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Several lanes, one quotient bit per register stage, with a travelling tag.
// The starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
module afr_div import afr_pkg::*; #(
	parameter int LANES    = DIV_LANES,
	parameter int DEN_BITS = DEN_W,
	parameter int Q_BITS   = QUO_W,
	parameter int TAG_W    = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [LANES-1:0][DEN_BITS-1:0]   in_den,
	input  logic [LANES-1:0][DEN_BITS-1:0]   in_rem,
	input  logic [LANES-1:0][Q_BITS-1:0]     in_low,
	input  logic [TAG_W-1:0]                 in_tag,
	output logic                             out_valid,
	output logic [LANES-1:0][Q_BITS-1:0]     out_quo,
	output logic [TAG_W-1:0]                 out_tag
);

	logic                           vld_s [Q_BITS+1];
	logic [LANES-1:0][DEN_BITS-1:0] den_s [Q_BITS+1];
	logic [LANES-1:0][DEN_BITS-1:0] rem_s [Q_BITS+1];
	logic [LANES-1:0][Q_BITS-1:0]   low_s [Q_BITS+1];
	logic [LANES-1:0][Q_BITS-1:0]   quo_s [Q_BITS+1];
	logic [TAG_W-1:0]               tag_s [Q_BITS+1];

	assign vld_s[0] = in_valid;
	assign den_s[0] = in_den;
	assign rem_s[0] = in_rem;
	assign low_s[0] = in_low;
	assign quo_s[0] = '0;
	assign tag_s[0] = in_tag;

	for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
		logic [LANES-1:0][DEN_BITS-1:0] rem_n;
		logic [LANES-1:0][Q_BITS-1:0]   quo_n;
		logic [LANES-1:0][Q_BITS-1:0]   low_n;

		always_comb begin
			logic [DEN_BITS:0] cat;
			logic              ge;
			for (int l = 0; l < LANES; l++) begin
				cat      = {rem_s[i][l], low_s[i][l][Q_BITS-1]};
				ge       = (cat >= {1'b0, den_s[i][l]});
				rem_n[l] = ge ? DEN_BITS'(cat - {1'b0, den_s[i][l]}) : cat[DEN_BITS-1:0];
				quo_n[l] = {quo_s[i][l][Q_BITS-2:0], ge};
				low_n[l] = {low_s[i][l][Q_BITS-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			den_s[i+1] <= den_s[i];
			rem_s[i+1] <= rem_n;
			low_s[i+1] <= low_n;
			quo_s[i+1] <= quo_n;
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = vld_s[Q_BITS];
	assign out_quo   = quo_s[Q_BITS];
	assign out_tag   = tag_s[Q_BITS];

endmodule

FILE: hdl/axis_face_refraction_unit.sv
// ----------------------------------------------------------------------------
// Axis-face refraction unit
// Refracts a ray at an axis-aligned cell face, or mirrors it on total
// internal reflection, and gives the index ratio that was applied.
//
//   Port group    Dir   Handshake        Contents
//   start/req     in    start & !busy    direction, face, both indices
//   done/rsp      out   done (1 cycle)   outgoing direction, reflected, eta
//
// A request is taken every cycle; busy stays low. Each result passes the
// front stages, the two 31-stage square roots, the normaliser stages, the
// 16-stage divider and the output register. The pipeline never holds:
// results leave in request order and the receiver takes each on its strobe
// cycle. Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module axis_face_refraction_unit import afr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  afr_req_t req,
	output logic     done,
	output afr_rsp_t rsp
);

	localparam int S1_W = $bits(afr_side1_t);
	localparam int S2_W = $bits(afr_side2_t);
	localparam int S3_W = $bits(afr_side3_t);

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---------------- Stage 1: face normal and clamped cosine ----------------
	dir_t [2:0]  din;
	logic [1:0]  axis_in;
	dir_t        d_a;
	logic [15:0] a_mag;
	logic [14:0] cmag_in;
	logic        sn_neg_in;

	assign din     = {req.dir_z, req.dir_y, req.dir_x};
	assign axis_in = req.face_axis[1] ? AXIS_Z : req.face_axis;

	always_comb begin
		case (axis_in)
			AXIS_X:  d_a = req.dir_x;
			AXIS_Y:  d_a = req.dir_y;
			default: d_a = req.dir_z;
		endcase
		a_mag   = d_a[15] ? 16'(~d_a + 16'd1) : 16'(d_a);
		cmag_in = (a_mag > {1'b0, COS_ONE}) ? COS_ONE : a_mag[14:0];
		// The normal always faces against the ray; in the face plane it stays as given.
		if (d_a == '0) begin
			sn_neg_in = ~req.face_positive;
		end else begin
			sn_neg_in = ~d_a[15];
		end
	end

	logic             valid_s1;
	dir_t [2:0]       d_s1;
	logic [1:0]       axis_s1;
	logic             sn_neg_s1;
	logic [14:0]      cmag_s1;
	logic [IOR_W-1:0] n1_s1;
	logic [IOR_W-1:0] n2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		d_s1      <= din;
		axis_s1   <= axis_in;
		sn_neg_s1 <= sn_neg_in;
		cmag_s1   <= cmag_in;
		n1_s1     <= req.ior_from;
		n2_s1     <= req.ior_to;
	end

	// ---------------- Stage 2: products and eta numerator ----------------
	logic [29:0]      cmag2_full;
	logic [30:0]      n1c_full;
	logic [2:0][32:0] n1d_full;
	logic [IOR_W-1:0] e_num_sel;
	logic [IOR_W-1:0] e_den_sel;
	logic [28:0]      e_num_c;
	afr_side1_t       side_c2;

	always_comb begin
		cmag2_full = cmag_s1 * cmag_s1;
		n1c_full   = n1_s1 * cmag_s1;
		for (int i = 0; i < 3; i++) begin
			n1d_full[i] = 33'($signed({1'b0, n1_s1}) * $signed(d_s1[i]));
		end
		if (d_s1[2][15] || (d_s1[2] == '0)) begin
			e_num_sel = n1_s1;
			e_den_sel = n2_s1;
		end else begin
			e_num_sel = n2_s1;
			e_den_sel = n1_s1;
		end
		e_num_c = {1'b0, e_num_sel, 12'b0} + 29'(e_den_sel[IOR_W-1:1]);

		side_c2.cy.d     = d_s1;
		side_c2.cy.axis  = axis_s1;
		side_c2.cy.tir   = 1'b0;
		side_c2.cy.e_num = e_num_c;
		side_c2.cy.e_den = e_den_sel;
		// A zero divisor lands here as well, giving the saturated ratio.
		side_c2.cy.e_sat = ({3'b0, e_num_c} >= {e_den_sel, 16'b0});
		side_c2.sn_neg   = sn_neg_s1;
		for (int i = 0; i < 3; i++) begin
			side_c2.n1d[i] = n1d_full[i][31:0];
		end
		side_c2.n1c = n1c_full[29:0];
	end

	logic        valid_s2;
	afr_side1_t  side_s2;
	logic [28:0] cmag2_s2;
	logic [31:0] n1sq_s2;
	logic [31:0] n2sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2  <= side_c2;
		cmag2_s2 <= cmag2_full[28:0];
		n1sq_s2  <= n1_s1 * n1_s1;
		n2sq_s2  <= n2_s1 * n2_s1;
	end

	// ---------------- Stage 3: both sides of the reflection test ----------------
	logic        valid_s3;
	afr_side1_t  side_s3;
	logic [60:0] lhs_s3;
	logic [60:0] rhs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		lhs_s3  <= n1sq_s2 * (COS_ONE_SQ - cmag2_s2);
		rhs_s3  <= {1'b0, n2sq_s2, 28'b0};
	end

	// ---------------- Stage 4: reflection decision ----------------
	logic        valid_s4;
	afr_side1_t  side_c4;
	afr_side1_t  side_s4;
	logic [60:0] k_s4;

	always_comb begin
		side_c4        = side_s3;
		side_c4.cy.tir = (lhs_s3 > rhs_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_c4;
		k_s4    <= rhs_s3 - lhs_s3;
	end

	// ---------------- Square root of k ----------------
	logic               sq1_valid;
	logic [SQ_RT_W-1:0] sq1_root;
	logic [S1_W-1:0]    sq1_tag;
	afr_side1_t         side_a;

	afr_isqrt #(
		.IN_W  (SQ_IN_W),
		.TAG_W (S1_W)
	) u_sqrt_k (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_x      ({1'b0, k_s4}),
		.in_tag    (side_s4),
		.out_valid (sq1_valid),
		.out_root  (sq1_root),
		.out_tag   (sq1_tag)
	);

	assign side_a = afr_side1_t'(sq1_tag);

	// ---------------- Stage 5: refracted vector, scaled by ior_to ----------------
	logic signed [31:0] m_c;
	logic signed [33:0] r_c [3];

	always_comb begin
		logic signed [33:0] base;
		logic signed [33:0] m_ext;
		m_c   = $signed({1'b0, sq1_root}) - $signed({2'b0, side_a.n1c});
		m_ext = {{2{m_c[31]}}, m_c};
		for (int i = 0; i < 3; i++) begin
			base = {{2{side_a.n1d[i][31]}}, side_a.n1d[i]};
			if (side_a.cy.axis == 2'(i)) begin
				r_c[i] = side_a.sn_neg ? (base + m_ext) : (base - m_ext);
			end else begin
				r_c[i] = base;
			end
		end
	end

	logic               valid_s5;
	afr_carry_t         cy_s5;
	logic signed [33:0] r_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= sq1_valid;
		end
	end

	always_ff @(posedge clk) begin
		cy_s5 <= side_a.cy;
		r_s5  <= r_c;
	end

	// ---------------- Stage 6: scale the vector below 2^30 ----------------
	logic [33:0]      magk [4][3];
	logic [3:0]       fit;
	logic [2:0][29:0] rmag_c;
	logic [2:0]       rneg_c;

	always_comb begin
		logic signed [33:0] sh;
		for (int k = 0; k < 4; k++) begin
			fit[k] = 1'b1;
			for (int i = 0; i < 3; i++) begin
				sh         = r_s5[i] >>> k;
				magk[k][i] = sh[33] ? 34'(-sh) : 34'(sh);
				fit[k]     = fit[k] & (magk[k][i][33:30] == 4'd0);
			end
		end
		for (int i = 0; i < 3; i++) begin
			rneg_c[i] = r_s5[i][33];
			if (fit[0]) begin
				rmag_c[i] = magk[0][i][29:0];
			end else if (fit[1]) begin
				rmag_c[i] = magk[1][i][29:0];
			end else if (fit[2]) begin
				rmag_c[i] = magk[2][i][29:0];
			end else begin
				rmag_c[i] = magk[3][i][29:0];
			end
		end
	end

	logic             valid_s6;
	afr_carry_t       cy_s6;
	logic [2:0][29:0] rmag_s6;
	logic [2:0]       rneg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		cy_s6   <= cy_s5;
		rmag_s6 <= rmag_c;
		rneg_s6 <= rneg_c;
	end

	// ---------------- Stage 7: squares ----------------
	logic             valid_s7;
	afr_carry_t       cy_s7;
	logic [2:0][29:0] rmag_s7;
	logic [2:0]       rneg_s7;
	logic [2:0][59:0] sq_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		cy_s7   <= cy_s6;
		rmag_s7 <= rmag_s6;
		rneg_s7 <= rneg_s6;
		for (int i = 0; i < 3; i++) begin
			sq_s7[i] <= rmag_s6[i] * rmag_s6[i];
		end
	end

	// ---------------- Stage 8: squared length ----------------
	logic               valid_s8;
	afr_side2_t         side_s8;
	logic [SQ_IN_W-1:0] sum_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		side_s8.cy   <= cy_s7;
		side_s8.rneg <= rneg_s7;
		side_s8.rmag <= rmag_s7;
		sum_s8       <= SQ_IN_W'(sq_s7[0]) + SQ_IN_W'(sq_s7[1]) + SQ_IN_W'(sq_s7[2]);
	end

	// ---------------- Square root of the length ----------------
	logic               sq2_valid;
	logic [SQ_RT_W-1:0] len_root;
	logic [S2_W-1:0]    sq2_tag;
	afr_side2_t         side_b;

	afr_isqrt #(
		.IN_W  (SQ_IN_W),
		.TAG_W (S2_W)
	) u_sqrt_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s8),
		.in_x      (sum_s8),
		.in_tag    (side_s8),
		.out_valid (sq2_valid),
		.out_root  (len_root),
		.out_tag   (sq2_tag)
	);

	assign side_b = afr_side2_t'(sq2_tag);

	// ---------------- Stage 9: rounded dividends ----------------
	logic [DIV_LANES-1:0][DEN_W-1:0] den_c;
	logic [DIV_LANES-1:0][DEN_W-1:0] rem_c;
	logic [DIV_LANES-1:0][QUO_W-1:0] low_c;
	afr_side3_t                      side_c9;

	always_comb begin
		logic [44:0] num;
		for (int i = 0; i < 3; i++) begin
			num      = {1'b0, side_b.rmag[i], 14'b0} + 45'(len_root[SQ_RT_W-1:1]);
			den_c[i] = len_root;
			rem_c[i] = DEN_W'(num[44:16]);
			low_c[i] = num[15:0];
		end
		den_c[ETA_LANE] = DEN_W'(side_b.cy.e_den);
		rem_c[ETA_LANE] = DEN_W'(side_b.cy.e_num[28:16]);
		low_c[ETA_LANE] = side_b.cy.e_num[15:0];

		side_c9.cy   = side_b.cy;
		// A refracted vector of zero length falls back to reflection.
		side_c9.cy.tir = side_b.cy.tir | (len_root == '0);
		side_c9.rneg = side_b.rneg;
	end

	logic                            valid_s9;
	afr_side3_t                      side_s9;
	logic [DIV_LANES-1:0][DEN_W-1:0] den_s9;
	logic [DIV_LANES-1:0][DEN_W-1:0] rem_s9;
	logic [DIV_LANES-1:0][QUO_W-1:0] low_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else begin
			valid_s9 <= sq2_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s9 <= side_c9;
		den_s9  <= den_c;
		rem_s9  <= rem_c;
		low_s9  <= low_c;
	end

	// ---------------- Divider: three components and eta ----------------
	logic                            div_valid;
	logic [DIV_LANES-1:0][QUO_W-1:0] div_quo;
	logic [S3_W-1:0]                 div_tag;
	afr_side3_t                      side_e;

	afr_div #(
		.LANES    (DIV_LANES),
		.DEN_BITS (DEN_W),
		.Q_BITS   (QUO_W),
		.TAG_W    (S3_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s9),
		.in_den    (den_s9),
		.in_rem    (rem_s9),
		.in_low    (low_s9),
		.in_tag    (side_s9),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_tag   (div_tag)
	);

	assign side_e = afr_side3_t'(div_tag);

	// ---------------- Output register ----------------
	dir_t [2:0]       o_c;
	logic [IOR_W-1:0] eta_c;

	always_comb begin
		dir_t q;
		for (int i = 0; i < 3; i++) begin
			q = {1'b0, div_quo[i][14:0]};
			if (side_e.cy.tir) begin
				o_c[i] = (side_e.cy.axis == 2'(i)) ? neg_sat(side_e.cy.d[i]) : side_e.cy.d[i];
			end else begin
				o_c[i] = side_e.rneg[i] ? dir_t'(-q) : q;
			end
		end
		if (side_e.cy.tir) begin
			eta_c = ETA_ONE;
		end else if (side_e.cy.e_sat) begin
			eta_c = ETA_SAT;
		end else begin
			eta_c = div_quo[ETA_LANE];
		end
	end

	logic     done_q;
	afr_rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.out_x     <= o_c[0];
		rsp_q.out_y     <= o_c[1];
		rsp_q.out_z     <= o_c[2];
		rsp_q.reflected <= side_e.cy.tir;
		rsp_q.eta_out   <= eta_c;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hdl/afr_checker.sv
// ----------------------------------------------------------------------------
// Axis-face refraction unit checker
// Port-level properties of the refraction unit, bound to its top level.
// ----------------------------------------------------------------------------
module afr_checker import afr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input afr_req_t req,
	input logic     done,
	input afr_rsp_t rsp
);

	// The pipeline never holds a request off.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every result stems from a request taken a fixed latency earlier.
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching request");

	// A reflected result always carries unit ratio.
	a_reflect_eta: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.reflected) |-> (rsp.eta_out == ETA_ONE))
		else $error("reflected result with ratio other than one");

	// A refracted result is a normalised vector, so it cannot be all zero.
	a_refract_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.reflected) |->
		(rsp.out_x != '0 || rsp.out_y != '0 || rsp.out_z != '0))
		else $error("refracted result of zero length");

endmodule

bind axis_face_refraction_unit afr_checker u_afr_checker (.*);

FILE: tb/axis_face_refraction_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-face refraction unit testbench
// Sends rays across cell faces, directed corner cases first and then random
// requests, and checks every result against a behavioural refraction
// predictor kept in request order.
// ----------------------------------------------------------------------------
module axis_face_refraction_unit_test import afr_pkg::*;;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	afr_req_t req;
	logic     done;
	afr_rsp_t rsp;

	afr_rsp_t refr_queue[$];
	int       mismatches;
	int       results_seen;
	int       reflections_seen;
	int       requests_sent;
	bit       idle_enable;

	axis_face_refraction_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned abs64(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic afr_rsp_t predict_refraction(input afr_req_t r);
		afr_rsp_t p;
		longint d[3], o[3], v[3];
		longint n1, n2, sn, c, m;
		longint unsigned one_m, lhs, rhs, big, sum, len, q, eta, num, den;
		int ax;
		bit tir;
		d[0] = r.dir_x;
		d[1] = r.dir_y;
		d[2] = r.dir_z;
		ax = (r.face_axis == 2'd3) ? 2 : int'(r.face_axis);
		n1 = r.ior_from;
		n2 = r.ior_to;
		sn = r.face_positive ? 1 : -1;
		if (sn * d[ax] > 0) sn = -sn;
		c = sn * d[ax];
		if (c < -16384) c = -16384;
		if (c > 16384) c = 16384;
		one_m = (64'd1 << 28) - longint'(c * c);
		lhs = longint'(n1 * n1) * one_m;
		rhs = longint'(n2 * n2) << 28;
		tir = lhs > rhs;
		if (!tir) begin
			m = n1 * c + longint'(int_sqrt(rhs - lhs));
			for (int i = 0; i < 3; i++) v[i] = n1 * d[i];
			v[ax] = v[ax] - m * sn;
			forever begin
				big = abs64(v[0]);
				if (abs64(v[1]) > big) big = abs64(v[1]);
				if (abs64(v[2]) > big) big = abs64(v[2]);
				if (big < (64'd1 << 30)) break;
				// Arithmetic shift floors, as the datapath does.
				for (int i = 0; i < 3; i++) v[i] = v[i] >>> 1;
			end
			sum = 0;
			for (int i = 0; i < 3; i++) sum += abs64(v[i]) * abs64(v[i]);
			len = int_sqrt(sum);
			if (len == 0) begin
				tir = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					q = ((abs64(v[i]) << 14) + (len >> 1)) / len;
					if (q > 32767) q = 32767;
					o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
				end
			end
		end
		if (tir) begin
			for (int i = 0; i < 3; i++) o[i] = d[i];
			o[ax] = -d[ax];
			if (o[ax] > 32767) o[ax] = 32767;
			eta = ETA_ONE;
		end else begin
			num = (d[2] <= 0) ? n1 : n2;
			den = (d[2] <= 0) ? n2 : n1;
			if (den == 0) eta = ETA_SAT;
			else eta = ((num << 12) + (den >> 1)) / den;
			if (eta > ETA_SAT) eta = ETA_SAT;
		end
		p.out_x = dir_t'(o[0]);
		p.out_y = dir_t'(o[1]);
		p.out_z = dir_t'(o[2]);
		p.reflected = tir;
		p.eta_out = eta[IOR_W-1:0];
		return p;
	endfunction

	// Leaves start high on return, so that requests can follow back to back.
	task automatic send_ray(input afr_req_t r);
		if (idle_enable) begin
			while ($urandom_range(99) < 13) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		refr_queue.push_back(predict_refraction(r));
		requests_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (refr_queue.size() != 0) @(posedge clk);
	endtask

	function automatic dir_t unit_dir(input int sel);
		case (sel)
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd11585;
			default: return -16'sd11585;
		endcase
	endfunction

	function automatic afr_req_t make_ray(input dir_t x, input dir_t y, input dir_t z,
			input logic [1:0] ax, input logic pos, input logic [15:0] a,
			input logic [15:0] b);
		afr_req_t r;
		r.dir_x = x; r.dir_y = y; r.dir_z = z;
		r.face_axis = ax; r.face_positive = pos;
		r.ior_from = a; r.ior_to = b;
		return r;
	endfunction

	task automatic test_corner_rays();
		send_ray(make_ray(16'sd0, 16'sd0, 16'sd16384, AXIS_Z, 1'b1, 16'h4000, 16'h6000));
		send_ray(make_ray(16'sd0, 16'sd0, -16'sd16384, AXIS_Z, 1'b0, 16'h6000, 16'h4000));
		send_ray(make_ray(16'sd16384, 16'sd0, 16'sd0, AXIS_X, 1'b1, 16'h4000, 16'h4000));
		send_ray(make_ray(16'sd0, -16'sd16384, 16'sd0, AXIS_Y, 1'b0, 16'h5000, 16'h4000));
		// Axis three behaves as z.
		send_ray(make_ray(16'sd11585, 16'sd0, 16'sd11585, 2'd3, 1'b1, 16'h4000, 16'h5000));
		// Grazing ray from dense to thin medium: total internal reflection.
		send_ray(make_ray(16'sd16000, 16'sd0, 16'sd3000, AXIS_Z, 1'b1, 16'h8000, 16'h4000));
		// Ray in the face plane keeps the face sign as given.
		send_ray(make_ray(16'sd16384, 16'sd0, 16'sd0, AXIS_Z, 1'b1, 16'h4000, 16'h6000));
		send_ray(make_ray(16'sd16384, 16'sd0, 16'sd0, AXIS_Z, 1'b0, 16'h6000, 16'h4000));
		// Zero direction gives a zero-length refraction.
		send_ray(make_ray(16'sd0, 16'sd0, 16'sd0, AXIS_X, 1'b1, 16'h4000, 16'h4000));
		// Most negative and largest components, with the cosine clamped to one.
		send_ray(make_ray(16'sd100, 16'sd0, DIR_MIN, AXIS_Z, 1'b1, 16'hFFFF, 16'h0001));
		send_ray(make_ray(DIR_MIN, DIR_MAX, DIR_MIN, AXIS_X, 1'b0, 16'hFFFF, 16'h0001));
		send_ray(make_ray(DIR_MAX, DIR_MAX, DIR_MAX, AXIS_Y, 1'b1, 16'hFFFF, 16'hFFFF));
		// Zero and extreme indices run without a fault.
		send_ray(make_ray(16'sd0, 16'sd0, 16'sd16384, AXIS_Z, 1'b1, 16'h4000, 16'h0000));
		send_ray(make_ray(16'sd0, 16'sd0, -16'sd16384, AXIS_Z, 1'b1, 16'h0000, 16'h4000));
		send_ray(make_ray(16'sd0, 16'sd0, 16'sd16384, AXIS_Z, 1'b0, 16'h0000, 16'h0000));
		send_ray(make_ray(16'sd0, 16'sd16384, 16'sd0, AXIS_Y, 1'b1, 16'h0001, 16'hFFFF));
		send_ray(make_ray(-16'sd1, -16'sd1, -16'sd1, AXIS_X, 1'b1, 16'h0001, 16'h0001));
	endtask

	task automatic test_random_rays(input int count);
		afr_req_t r;
		for (int i = 0; i < count; i++) begin
			idle_enable = !(i >= count / 3 && i < count / 2);
			if ($urandom_range(99) < 70) begin
				// Components within unit range, with plausible indices.
				r.dir_x = dir_t'($urandom_range(32768) - 16384);
				r.dir_y = dir_t'($urandom_range(32768) - 16384);
				r.dir_z = dir_t'($urandom_range(32768) - 16384);
				if ($urandom_range(3) == 0) r.dir_z = unit_dir($urandom_range(3));
				r.ior_from = 16'($urandom_range(16'h9000, 16'h3000));
				r.ior_to   = 16'($urandom_range(16'h9000, 16'h3000));
			end else begin
				r.dir_x = dir_t'($urandom);
				r.dir_y = dir_t'($urandom);
				r.dir_z = dir_t'($urandom);
				r.ior_from = 16'($urandom);
				r.ior_to   = 16'($urandom);
			end
			r.face_axis = 2'($urandom_range(3));
			r.face_positive = 1'($urandom);
			send_ray(r);
			if (i == count / 4) wait_drained();
		end
		idle_enable = 1'b1;
	endtask

	always @(posedge clk) begin
		afr_rsp_t exp_rsp;
		if (done) begin
			results_seen++;
			if (rsp.reflected) reflections_seen++;
			if (refr_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %p", rsp);
			end else begin
				exp_rsp = refr_queue.pop_front();
				if (rsp.out_x !== exp_rsp.out_x || rsp.out_y !== exp_rsp.out_y ||
						rsp.out_z !== exp_rsp.out_z ||
						rsp.reflected !== exp_rsp.reflected ||
						rsp.eta_out !== exp_rsp.eta_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", exp_rsp, rsp);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		mismatches = 0;
		results_seen = 0;
		reflections_seen = 0;
		requests_sent = 0;
		idle_enable = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_rays();
		test_random_rays(1150);
		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		if (refr_queue.size() != 0) mismatches++;
		$display("Sent %0d rays, checked %0d results, %0d of them reflected.",
			requests_sent, results_seen, reflections_seen);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/afr_pkg.sv
hdl/afr_isqrt.sv
hdl/afr_div.sv
hdl/axis_face_refraction_unit.sv
hdl/afr_checker.sv
tb/axis_face_refraction_unit_test.sv
